// ===== src/bra_pkg.sv =====
package bra_pkg;

    // Field widths fixed by the item format
    localparam int IDX_BITS = 8;
    localparam int CNT_BITS = 9;

    // free_index has 8 bits, so no index at or above this is ever reported
    localparam int INDEX_LIMIT = 256;

    localparam logic [CNT_BITS-1:0] RESET_COUNT = 9'd256;

    localparam logic FUNC_FIND = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // Search token that walks down the row of cells
    typedef struct packed {
        logic                active;
        logic                found;
        logic [IDX_BITS-1:0] index;
    } probe_t;

    // Set command, broadcast to every cell
    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] index;
        logic                mark_free;
    } set_cmd_t;

    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] index;
    } result_t;

endpackage

// ===== src/bra_req_if.sv =====
interface bra_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] target_index;
    logic       mark_free;

    modport source (output valid, output func, output target_index, output mark_free,
                    input ready);
    modport sink   (input valid, input func, input target_index, input mark_free,
                    output ready);
endinterface

// ===== src/bra_rsp_if.sv =====
interface bra_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] free_index;

    modport source (output valid, output found, output free_index, input ready);
    modport sink   (input valid, input found, input free_index, output ready);
endinterface

// ===== src/bra_cell.sv =====
module bra_cell #(
    parameter int WORD_BITS     = 32,
    parameter int CELL_IDX      = 0,
    parameter int MAX_RESOURCES = 256,
    parameter int IDX_W         = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bra_pkg::CNT_BITS-1:0] limit,
    input  bra_pkg::set_cmd_t         set_cmd,
    input  bra_pkg::probe_t           probe_in,
    output bra_pkg::probe_t           probe_out
);
    import bra_pkg::*;

    localparam int POS_W = $clog2(WORD_BITS);
    localparam int BASE  = CELL_IDX * WORD_BITS;
    localparam logic [IDX_W-1:0] BASE_V = IDX_W'(BASE);
    localparam logic [IDX_W-1:0] TOP_V  = IDX_W'(BASE + WORD_BITS);
    localparam logic [IDX_W-1:0] MAX_V  = IDX_W'(MAX_RESOURCES);

    logic [WORD_BITS-1:0] word_reg, word_next;
    probe_t               probe_reg, probe_next;

    logic [IDX_W-1:0] set_idx;
    logic [IDX_W-1:0] set_off;
    logic [POS_W-1:0] set_pos;
    logic             set_hit;
    logic [IDX_W-1:0] limit_ext;
    logic [WORD_BITS-1:0] free_vec;
    logic [POS_W-1:0] low_pos;
    logic             any_free;

    assign set_idx   = IDX_W'(set_cmd.index);
    assign set_off   = set_idx - BASE_V;
    assign set_pos   = set_off[POS_W-1:0];
    assign set_hit   = set_cmd.en && (set_idx >= BASE_V) && (set_idx < TOP_V)
                       && (set_idx < MAX_V);
    assign limit_ext = IDX_W'(limit);

    // Update the stored word on a set hit
    always_comb
    begin
        word_next = word_reg;
        if (set_hit)
        begin
            word_next[set_pos] = !set_cmd.mark_free;
        end
    end

    // Free bits that lie below the resource limit
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_vec[b] = !word_reg[b] && (IDX_W'(BASE + b) < limit_ext);
        end
    end

    // Lowest free bit in this word
    always_comb
    begin
        low_pos  = '0;
        any_free = 1'b0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_vec[b])
            begin
                low_pos  = POS_W'(b);
                any_free = 1'b1;
            end
        end
    end

    // Claim the token if no earlier cell answered
    always_comb
    begin
        probe_next = probe_in;
        if (probe_in.active && !probe_in.found && any_free)
        begin
            probe_next.found = 1'b1;
            probe_next.index = IDX_BITS'(BASE + int'(low_pos));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            probe_reg <= '0;
        end
        else
        begin
            word_reg  <= word_next;
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

// ===== src/bitmap_resource_allocator.sv =====
// Bitmap resource allocator: one usage bit per resource, 0 free and 1 used.
// Request channel (req): func selects find (lowest free index) or set (mark
// one index free or used by target_index and mark_free). Response channel (rsp):
// exactly one transaction per request, found and free_index; a set request
// answers with both zero. Config: cfg_we writes cfg_wdata into resource_count;
// indices at or above it (capped at the bitmap size and at 256) are never
// returned. Write it only while the block is idle.
// Search: a find walks a token down a row of NUM_WORDS cells, one bitmap word
// per cycle, then through the holding register into the output register.
// A set goes through the holding register into the output register.
// One request is in flight at a time, so a new request is taken only after
// the last one has been handed to the output register.
// Reset clears the bitmap to all free and sets resource_count to 256.
// If the receiver stalls, the response holds in the output register while the
// next request is still accepted; that request's result waits in a holding
// register, and req.ready drops until the output register drains.
module bitmap_resource_allocator #(
    parameter int MAX_RESOURCES = 256,
    parameter int WORD_BITS     = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bra_req_if.sink                       req,
    bra_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [bra_pkg::CNT_BITS-1:0]  cfg_wdata
);
    import bra_pkg::*;

    localparam int NUM_WORDS = (MAX_RESOURCES + WORD_BITS - 1) / WORD_BITS;
    localparam int SPAN      = NUM_WORDS * WORD_BITS;
    localparam int IDX_RAW   = $clog2(SPAN + 1);
    localparam int IDX_W     = (IDX_RAW > CNT_BITS) ? IDX_RAW : CNT_BITS;
    localparam int LIM_INT   = (MAX_RESOURCES < INDEX_LIMIT) ? MAX_RESOURCES : INDEX_LIMIT;
    localparam logic [CNT_BITS-1:0] LIMIT_CAP = CNT_BITS'(LIM_INT);

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   limit;
    result_t               pend_reg, pend_next;
    result_t               out_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  load_out;
    logic                  accept;
    logic                  slot_free;
    set_cmd_t              set_cmd;
    probe_t                probe [NUM_WORDS+1];

    // Take a new request only in the idle state, between requests
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;

    // Clamp the configured count to what the bitmap and free_index can hold
    assign limit = (count_reg > LIMIT_CAP) ? LIMIT_CAP : count_reg;

    // Broadcast a set to every cell; the owning cell updates its word
    assign set_cmd.en        = accept && (req.func == FUNC_SET);
    assign set_cmd.index     = req.target_index;
    assign set_cmd.mark_free = req.mark_free;

    // Inject the search token into the first cell
    assign probe[0].active = accept && (req.func == FUNC_FIND);
    assign probe[0].found  = 1'b0;
    assign probe[0].index  = '0;

    for (genvar g = 0; g < NUM_WORDS; g++)
    begin : g_cell
        bra_cell #(
            .WORD_BITS     (WORD_BITS),
            .CELL_IDX      (g),
            .MAX_RESOURCES (MAX_RESOURCES),
            .IDX_W         (IDX_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .limit     (limit),
            .set_cmd   (set_cmd),
            .probe_in  (probe[g]),
            .probe_out (probe[g+1])
        );
    end

    // Sequence: accept, walk the row for a find, then hand off to the output register
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == FUNC_SET)
                    begin
                        pend_next  = '0;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Token leaves the last cell: capture the answer
                if (probe[NUM_WORDS].active)
                begin
                    pend_next.found = probe[NUM_WORDS].found;
                    pend_next.index = probe[NUM_WORDS].index;
                    state_next      = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // Wait for the output register to drain
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= RESET_COUNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (load_out)
        begin
            out_data_reg <= pend_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_data_reg.found;
    assign rsp.free_index = out_data_reg.index;

endmodule

// ===== tb/bitmap_resource_allocator_tb.sv =====
module bitmap_resource_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bra_pkg::*;

    localparam int BITMAP_SIZE = 256;
    localparam int WORD_WIDTH  = 32;

    // A find walks NUM_WORDS cells, the holding and the output register; allow some margin
    localparam int SETTLE_CYCLES = BITMAP_SIZE / WORD_WIDTH + 6;

    // Roughly 1500 transactions; the timeout leaves a wide margin over them
    localparam longint TIMEOUT_NS = 5_000_000;

    localparam logic MARK_FREE = 1'b1;
    localparam logic MARK_USED = 1'b0;

    localparam int NUM_PHASES = 10;

    // Shadow copy of the usage bitmap and resource_count. Each accepted request
    // updates the copy and queues the response the block owes for it.
    class alloc_scoreboard;
        logic [BITMAP_SIZE-1:0] usage;
        logic [CNT_BITS-1:0]    count;
        result_t                pending[$];
        int                     errors;

        function new();
            usage  = '0;
            count  = RESET_COUNT;
            errors = 0;
        endfunction

        function void write_count(logic [CNT_BITS-1:0] value);
            count = value;
        endfunction

        // Lowest free index below lim, or -1 when every bit below it is used
        function int lowest_free(int lim);
            for (int i = 0; i < lim; i++)
                if (!usage[i])
                    return i;
            return -1;
        endfunction

        // Effective search limit: count clamped to the bitmap and to 8-bit indices
        function int search_limit();
            int lim;
            lim = int'(count);
            if (lim > BITMAP_SIZE)
                lim = BITMAP_SIZE;
            if (lim > INDEX_LIMIT)
                lim = INDEX_LIMIT;
            return lim;
        endfunction

        function void note_request(logic func, logic [IDX_BITS-1:0] idx, logic mf);
            result_t exp_res;
            int      hit;
            exp_res = '0;
            if (func == FUNC_SET) begin
                if (idx < BITMAP_SIZE)
                    usage[idx] = (mf == MARK_FREE) ? 1'b0 : 1'b1;
            end
            else begin
                hit = lowest_free(search_limit());
                if (hit >= 0) begin
                    exp_res.found = 1'b1;
                    exp_res.index = hit[IDX_BITS-1:0];
                end
            end
            pending.push_back(exp_res);
        endfunction

        function void check_response(logic found, logic [IDX_BITS-1:0] idx);
            result_t exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response: found=%0b free_index=%0d",
                         $time, found, idx);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (found !== exp_res.found) begin
                $display("%0t: found mismatch: expected %0b, actual %0b",
                         $time, exp_res.found, found);
                errors++;
            end
            if (idx !== exp_res.index) begin
                $display("%0t: free_index mismatch: expected %0d, actual %0d",
                         $time, exp_res.index, idx);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CNT_BITS-1:0] cfg_wdata;

    // Set for the closing stretch: no idling on either side
    bit quiet;

    alloc_scoreboard sb;

    bra_req_if req_ch ();
    bra_rsp_if rsp_ch ();

    bitmap_resource_allocator #(
        .MAX_RESOURCES (BITMAP_SIZE),
        .WORD_BITS     (WORD_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("bitmap_resource_allocator_tb failed");
        $finish;
    end

    // Check every response transaction against the oldest queued expectation.
    // Sampling at the edge sees the values that were set up before it.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.found, rsp_ch.free_index);
    end

    // Receiver: hold ready high for a random stretch, then now and then drop it
    // for a random burst. Stop stalling once quiet is set.
    initial
    begin
        rsp_ch.ready <= 1'b1;
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet && $urandom_range(0, 1) == 1) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Present one request and hold it until the block takes it. Valid stays
    // high on return so a following request can go out back to back.
    task automatic send_request(input logic func, input logic [IDX_BITS-1:0] idx,
                                input logic mf);
        req_ch.valid        <= 1'b1;
        req_ch.func         <= func;
        req_ch.target_index <= idx;
        req_ch.mark_free    <= mf;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(func, idx, mf);
    endtask

    // Sender gap: drop valid for a random burst of cycles now and then
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic issue(input logic func, input logic [IDX_BITS-1:0] idx, input logic mf);
        sender_gap();
        send_request(func, idx, mf);
    endtask

    // Stop sending and wait until every expected response has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Write resource_count only with the block idle
    task automatic write_count(input logic [CNT_BITS-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_count(value);
        cfg_we    <= 1'b0;
    endtask

    // One random phase. A share of it, set by alloc_pct, is the usual allocator
    // pattern: find the lowest free resource, then mark that one used. The rest
    // frees resources (biased toward low indices so the search limit matters),
    // issues lone finds, or sends fully random noise.
    task automatic run_phase(input int num_items, input int alloc_pct, input bit pause_mid);
        int                  sent;
        int                  pick;
        int                  hit;
        bit                  paused;
        logic [IDX_BITS-1:0] idx;
        sent   = 0;
        paused = 1'b0;
        while (sent < num_items) begin
            // Hold off once mid-phase until the block has answered everything
            if (pause_mid && !paused && sent >= num_items / 2) begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                issue(FUNC_FIND, IDX_BITS'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
                hit = sb.lowest_free(BITMAP_SIZE);
                idx = (hit >= 0) ? hit[IDX_BITS-1:0] : IDX_BITS'($urandom_range(0, 255));
                issue(FUNC_SET, idx, MARK_USED);
                sent += 2;
            end
            else if (pick < alloc_pct + 12) begin
                issue(1'($urandom_range(0, 1)), IDX_BITS'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < alloc_pct + 20) begin
                issue(FUNC_FIND, IDX_BITS'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
                sent++;
            end
            else begin
                idx = ($urandom_range(0, 1) == 1) ? IDX_BITS'($urandom_range(0, 255))
                                                  : IDX_BITS'($urandom_range(0, 63));
                issue(FUNC_SET, idx, MARK_FREE);
                sent++;
            end
        end
    endtask

    int                  phase_items [NUM_PHASES];
    int                  phase_alloc [NUM_PHASES];
    logic [CNT_BITS-1:0] phase_count [NUM_PHASES];

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_FIND;
        req_ch.target_index <= '0;
        req_ch.mark_free    <= MARK_USED;
        quiet = 1'b0;
        sb    = new();

        // Phase plan: the first one fills the bitmap under a clamped count,
        // later ones mix frees and allocations under small, zero and
        // oversized counts. The last one runs without any idling.
        phase_count = '{9'd511, 9'd256, 9'd37, 9'd1, 9'd0,
                        9'd255, 9'd257, 9'd200, 9'd100, 9'd256};
        phase_items = '{520, 120, 120, 60, 40, 120, 80, 140, 100, 150};
        phase_alloc = '{85, 35, 60, 50, 50, 40, 70, 55, 50, 50};
        phase_count[8] = CNT_BITS'($urandom_range(1, 256));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all free after reset, with the reset count
        issue(FUNC_FIND, 8'd0, MARK_USED);      // lowest free is 0
        issue(FUNC_SET, 8'd0, MARK_USED);       // set answers with zeros
        issue(FUNC_FIND, 8'd255, MARK_FREE);    // now 1
        issue(FUNC_FIND, 8'd0, MARK_USED);      // find marks nothing: still 1
        issue(FUNC_SET, 8'd255, MARK_USED);     // top index
        issue(FUNC_SET, 8'd0, MARK_FREE);       // free clears the bit
        issue(FUNC_FIND, 8'd0, MARK_USED);      // back to 0
        issue(FUNC_SET, 8'd255, MARK_FREE);

        // Count of one: nothing free below it once index 0 is used
        write_count(9'd1);
        issue(FUNC_FIND, 8'd0, MARK_USED);      // 0 found
        issue(FUNC_SET, 8'd0, MARK_USED);
        issue(FUNC_FIND, 8'd0, MARK_USED);      // not found
        issue(FUNC_SET, 8'd200, MARK_USED);     // above the count, still updated

        // Count of zero: find never succeeds
        write_count(9'd0);
        issue(FUNC_SET, 8'd0, MARK_FREE);
        issue(FUNC_FIND, 8'd0, MARK_USED);

        // Oversized count clamps to the bitmap size
        write_count(9'd511);
        issue(FUNC_FIND, 8'd0, MARK_USED);      // 0 found
        issue(FUNC_SET, 8'd0, MARK_USED);
        issue(FUNC_SET, 8'd1, MARK_USED);
        issue(FUNC_FIND, 8'd0, MARK_USED);      // 2 found
        issue(FUNC_SET, 8'd200, MARK_FREE);     // undo the set above the count
        issue(FUNC_SET, 8'd1, MARK_FREE);
        issue(FUNC_FIND, 8'd0, MARK_USED);      // 1 found

        // Random phases, each under its own resource_count
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_count(phase_count[p]);
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            run_phase(phase_items[p], phase_alloc[p], p == 2);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("bitmap_resource_allocator_tb passed");
        else
            $display("bitmap_resource_allocator_tb failed");
        $finish;
    end

endmodule
